// File: design/dwtas_pkg.sv
// dwtas_pkg: shared widths, types, tap defaults and helpers for the wavelet
// analysis stage. Depends on nothing; used by dwtas_cell and the top level.
package dwtas_pkg;

	localparam int TAPS = 4;
	// number of filter taps in use, held to the supported range
	localparam int TAP_USE = (TAPS < 2) ? 2 : ((TAPS > 4) ? 4 : TAPS);

	localparam int SMP_W = 16;
	localparam int COEF_W = 16;
	localparam int PROD_W = SMP_W + COEF_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int OUT_W = 20;
	localparam int FRAC_W = 15;
	localparam int NUM_TAP_REGS = 4;
	localparam int CFG_IDX_W = 3;

	// registers below this index are lowpass taps, the rest highpass taps
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BASE = 3'd4;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [OUT_W-1:0] res_t;

	typedef coef_t tap_arr_t [NUM_TAP_REGS];

	localparam tap_arr_t LOW_TAP_RST = '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0};
	localparam tap_arr_t HIGH_TAP_RST = '{16'sd23170, -16'sd23170, 16'sd0, 16'sd0};

	// taps for the two pairs a sample can produce (second pair only on flush)
	typedef struct packed {
		coef_t lo_a;
		coef_t hi_a;
		coef_t lo_b;
		coef_t hi_b;
	} tap_sel_t;

	typedef struct packed {
		acc_t lo_a;
		acc_t hi_a;
		acc_t lo_b;
		acc_t hi_b;
	} psum_t;

	// tap j, or zero where j lies past the filter length
	function automatic coef_t sel_tap(tap_arr_t t, logic [2:0] j);
		coef_t r;
		r = '0;
		if (j < 3'(TAP_USE)) begin
			r = t[j[1:0]];
		end
		return r;
	endfunction

	// Q4.30 sum to Q5.15, round half towards plus infinity
	function automatic res_t round_q415(acc_t a);
		acc_t t;
		t = a + acc_t'(1 << (FRAC_W - 1));
		t = t >>> FRAC_W;
		return t[OUT_W-1:0];
	endfunction

endpackage

// File: design/dwt_analysis_stage_unit.sv
// dwt_analysis_stage_unit: one level of a two-channel wavelet analysis bank.
// Pipeline: the accepting edge registers the tap products, s2 registers the rounded
// pairs, then the output register drives m_tvalid; a flushed second pair follows the first.
// Throughput: one sample per clock while the output is not back-pressured; each tap cell
// forms all four products of a sample together; a last sample that gives two pairs
// holds s_tready low while s2 still holds both pairs.
// Reset: clears the delay cells, parity and pipeline; taps return to defaults.
// Depends on dwtas_pkg and dwtas_cell.
module dwt_analysis_stage_unit import dwtas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] sample_in
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // [19:0] approx_out, [39:20] detail_out
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	tap_arr_t low_tap_q;
	tap_arr_t high_tap_q;
	logic     odd_q;

	logic     s_acc;
	logic     da;
	logic     in_va;
	logic     in_vb;
	logic     in_lasta;

	smp_t     win [TAP_USE+1];
	psum_t    ps [TAP_USE+1];
	tap_sel_t sel [TAP_USE];

	logic     va_s1;
	logic     vb_s1;
	logic     lasta_s1;
	logic     s1_valid;
	logic     va_s2;
	logic     vb_s2;
	logic     lasta_s2;
	res_t     app_a_s2;
	res_t     det_a_s2;
	res_t     app_b_s2;
	res_t     det_b_s2;

	logic     m_valid_q;
	res_t     app_q;
	res_t     det_q;
	logic     last_q;

	logic     out_free;
	logic     s2_any;
	logic     s2_drain_ok;
	logic     s1_move;
	logic     out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_tap_q  <= LOW_TAP_RST;
			high_tap_q <= HIGH_TAP_RST;
		end else if (cfg_valid) begin
			if (cfg_index < CFG_HIGH_BASE) begin
				low_tap_q[cfg_index[1:0]] <= cfg_data;
			end else begin
				high_tap_q[cfg_index[1:0]] <= cfg_data;
			end
		end
	end

	assign s_acc = s_tvalid && s_tready;

	// flush of an odd last position starts one tap further along
	assign da       = s_tlast & odd_q;
	assign in_va    = s_tlast || !odd_q;
	assign in_vb    = s_tlast && ((3'({2'b00, da}) + 3'd2) < 3'(TAP_USE));
	assign in_lasta = s_tlast && !in_vb;

	assign win[0] = smp_t'(s_tdata);
	assign ps[0]  = '0;

	for (genvar k = 0; k < TAP_USE; k++) begin : g_cell
		logic [2:0] ja;
		logic [2:0] jb;

		assign ja = 3'(k) + {2'b00, da};
		assign jb = ja + 3'd2;

		always_comb begin
			sel[k].lo_a = sel_tap(low_tap_q, ja);
			sel[k].hi_a = sel_tap(high_tap_q, ja);
			sel[k].lo_b = sel_tap(low_tap_q, jb);
			sel[k].hi_b = sel_tap(high_tap_q, jb);
		end

		dwtas_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld       (s_acc),
			.clr      (s_tlast),
			.w_in     (win[k]),
			.taps     (sel[k]),
			.psum_in  (ps[k]),
			.w_out    (win[k+1]),
			.psum_out (ps[k+1])
		);
	end

	// s2 holds up to two pairs and hands them out one per request
	assign s1_valid    = va_s1 | vb_s1;
	assign out_free    = !m_valid_q || m_tready;
	assign s2_any      = va_s2 | vb_s2;
	assign s2_drain_ok = !s2_any || (out_free && (va_s2 ^ vb_s2));
	assign s1_move     = s1_valid && s2_drain_ok;
	assign out_load    = out_free && s2_any;
	assign s_tready    = !s1_valid || s2_drain_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q <= 1'b0;
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
		end else if (s_acc) begin
			odd_q <= s_tlast ? 1'b0 : !odd_q;
			va_s1 <= in_va;
			vb_s1 <= in_vb;
		end else if (s1_move) begin
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			lasta_s1 <= in_lasta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s2 <= 1'b0;
			vb_s2 <= 1'b0;
		end else if (s1_move) begin
			va_s2 <= va_s1;
			vb_s2 <= vb_s1;
		end else if (out_load) begin
			if (va_s2) begin
				va_s2 <= 1'b0;
			end else begin
				vb_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			lasta_s2 <= lasta_s1;
			app_a_s2 <= round_q415(ps[TAP_USE].lo_a);
			det_a_s2 <= round_q415(ps[TAP_USE].hi_a);
			app_b_s2 <= round_q415(ps[TAP_USE].lo_b);
			det_b_s2 <= round_q415(ps[TAP_USE].hi_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// the second pair only exists on a flush and always closes the signal
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (va_s2) begin
				app_q  <= app_a_s2;
				det_q  <= det_a_s2;
				last_q <= lasta_s2;
			end else begin
				app_q  <= app_b_s2;
				det_q  <= det_b_s2;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {det_q, app_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast) |=> (!odd_q && win[1] == '0 && win[TAP_USE] == '0))
		else $error("delay cells not cleared after last sample");

	a_odd_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !s_tlast && odd_q) |=> !s1_valid)
		else $error("odd position produced a result");

	a_last_pair_final: assert property (@(posedge clk) disable iff (!arst_n)
		(va_s2 && lasta_s2) |-> !vb_s2)
		else $error("pair queued after a pair marked last");
`endif

endmodule

// File: design/dwtas_cell.sv
// dwtas_cell: one tap cell of the analysis filter chain; holds one delayed
// sample, registers its four products and adds them to the passing sums.
// Depends on dwtas_pkg.
module dwtas_cell import dwtas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     ld,
	input  logic     clr,
	input  smp_t     w_in,
	input  tap_sel_t taps,
	input  psum_t    psum_in,
	output smp_t     w_out,
	output psum_t    psum_out
);

	smp_t  hold_q;
	prod_t lo_a_s1;
	prod_t hi_a_s1;
	prod_t lo_b_s1;
	prod_t hi_b_s1;

	// delay element, emptied once the signal ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (ld) begin
			hold_q <= clr ? '0 : w_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			lo_a_s1 <= $signed(w_in) * $signed(taps.lo_a);
			hi_a_s1 <= $signed(w_in) * $signed(taps.hi_a);
			lo_b_s1 <= $signed(w_in) * $signed(taps.lo_b);
			hi_b_s1 <= $signed(w_in) * $signed(taps.hi_b);
		end
	end

	assign w_out = hold_q;

	always_comb begin
		psum_out.lo_a = psum_in.lo_a + acc_t'(lo_a_s1);
		psum_out.hi_a = psum_in.hi_a + acc_t'(hi_a_s1);
		psum_out.lo_b = psum_in.lo_b + acc_t'(lo_b_s1);
		psum_out.hi_b = psum_in.hi_b + acc_t'(hi_b_s1);
	end

endmodule

// File: verif/dwt_analysis_stage_unit_test.sv
// dwt_analysis_stage_unit_test: self-checking bench for the wavelet analysis stage.
// Streams signals in, predicts every approximation/detail pair and compares results.
// Depends on dwtas_pkg and the dwt_analysis_stage_unit design.
module dwt_analysis_stage_unit_test import dwtas_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam smp_t SMP_MIN = 16'sh8000;
	localparam smp_t SMP_MAX = 16'sh7fff;
	localparam coef_t TAP_MIN = 16'sh8000;
	localparam coef_t TAP_MAX = 16'sh7fff;
	localparam coef_t TAP_HALF = 16'sh4000;
	localparam int unsigned RANDOM_ITEMS = 1800;

	typedef struct {
		res_t approx;
		res_t detail;
		logic last;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state
	coef_t low_tap [NUM_TAP_REGS];
	coef_t high_tap [NUM_TAP_REGS];
	smp_t hist [3];
	logic odd_pos;
	pair_t expected_pairs [$];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned src_idle = 0;
	int unsigned sink_idle = 0;
	int unsigned sink_hold = 0;
	int unsigned sink_gap = 0;

	dwt_analysis_stage_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned rand_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic res_t q415(input longint acc);
		longint r;
		r = (acc + 64'sd16384) >>> 15;
		return r[OUT_W-1:0];
	endfunction

	// output at position m + delay from window win[k] = x[m-k]; later samples are zero
	function automatic pair_t filter_pair(input longint win [4], input int delay,
			input logic fin);
		longint lo_acc;
		longint hi_acc;
		pair_t p;
		lo_acc = 0;
		hi_acc = 0;
		for (int j = delay; j < TAP_USE; j++) begin
			lo_acc += longint'(low_tap[j]) * win[j - delay];
			hi_acc += longint'(high_tap[j]) * win[j - delay];
		end
		p.approx = q415(lo_acc);
		p.detail = q415(hi_acc);
		p.last = fin;
		return p;
	endfunction

	task automatic queue_pair(input pair_t p);
		expected_pairs = {expected_pairs, p};
	endtask

	task automatic predict_pairs(input smp_t x, input logic last);
		longint win [4];
		win[0] = x;
		win[1] = hist[0];
		win[2] = hist[1];
		win[3] = hist[2];
		if (!last) begin
			if (!odd_pos) begin
				queue_pair(filter_pair(win, 0, 1'b0));
			end
			hist[2] = hist[1];
			hist[1] = hist[0];
			hist[0] = x;
			odd_pos = !odd_pos;
		end else begin
			// flush the tail with zeros, every even position left
			for (int d = odd_pos ? 1 : 0; d < TAP_USE; d += 2) begin
				queue_pair(filter_pair(win, d, (d + 2) >= TAP_USE));
			end
			hist[0] = '0;
			hist[1] = '0;
			hist[2] = '0;
			odd_pos = 1'b0;
		end
	endtask

	task automatic reset_model();
		for (int k = 0; k < NUM_TAP_REGS; k++) begin
			low_tap[k] = LOW_TAP_RST[k];
			high_tap[k] = HIGH_TAP_RST[k];
		end
		hist[0] = '0;
		hist[1] = '0;
		hist[2] = '0;
		odd_pos = 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		error_count++;
	endtask

	// request monitor: predict on accepted samples, check accepted pairs
	always @(posedge clk) begin
		pair_t want;
		if (arst_n && s_tvalid && s_tready) begin
			predict_pairs(s_tdata, s_tlast);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected pair approx %0d detail %0d last %0b",
					$signed(m_tdata[19:0]), $signed(m_tdata[39:20]), m_tlast));
			end else begin
				want = expected_pairs.pop_front();
				if (m_tdata[19:0] !== want.approx || m_tdata[39:20] !== want.detail ||
						m_tlast !== want.last) begin
					report_mismatch($sformatf(
						"got approx %0d detail %0d last %0b, want %0d %0d %0b",
						$signed(m_tdata[19:0]), $signed(m_tdata[39:20]), m_tlast,
						want.approx, want.detail, want.last));
				end
			end
		end
	end

	// receiver: long hold-off on demand, otherwise random stalls
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (sink_gap != 0) begin
			m_tready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (sink_idle != 0 && $urandom_range(0, 99) < sink_idle) begin
			m_tready <= 1'b0;
			sink_gap <= rand_gap() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_sample(input smp_t x, input logic last);
		if (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			repeat (rand_gap()) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	function automatic smp_t rand_sample();
		case ($urandom_range(0, 15)) inside
			0, 1: return SMP_MIN;
			2, 3: return SMP_MAX;
			4: return '0;
			default: return smp_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_tap();
		case ($urandom_range(0, 11))
			0: return TAP_MIN;
			1: return TAP_MAX;
			2: return '0;
			default: return coef_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_length();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			return $urandom_range(1, 12);
		end else if (sel < 96) begin
			return $urandom_range(13, 60);
		end
		return $urandom_range(100, 200);
	endfunction

	function automatic int unsigned pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	task automatic send_signal(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_sample(rand_sample(), i == len - 1);
		end
	endtask

	// stop sending and wait for every pending pair, then let the pipeline settle
	task automatic drain_pipeline();
		int unsigned waited;
		s_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (expected_pairs.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic load_taps(input tap_arr_t lo, input tap_arr_t hi);
		for (int i = 0; i < 2 * NUM_TAP_REGS; i++) begin
			cfg_valid <= 1'b1;
			if (i < NUM_TAP_REGS) begin
				cfg_index <= CFG_IDX_W'(i);
				cfg_data <= lo[i];
			end else begin
				cfg_index <= CFG_HIGH_BASE + CFG_IDX_W'(i - NUM_TAP_REGS);
				cfg_data <= hi[i - NUM_TAP_REGS];
			end
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (i < NUM_TAP_REGS) begin
				low_tap[i] = lo[i];
			end else begin
				high_tap[i - NUM_TAP_REGS] = hi[i - NUM_TAP_REGS];
			end
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// haar taps out of reset, last sample at an odd position
	task automatic test_default_taps();
		src_idle = 0;
		sink_idle = 0;
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		drain_pipeline();
	endtask

	// extreme taps and samples, flush from even and odd positions, one-sample signal
	task automatic test_flush_extremes();
		load_taps('{TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN}, '{TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX});
		send_sample(SMP_MIN, 1'b1);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		send_sample(SMP_MAX, 1'b0);
		send_sample('0, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		drain_pipeline();
		load_taps('{TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN}, '{TAP_MIN, TAP_MAX, TAP_MIN, TAP_MAX});
		sink_idle = 30;
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b1);
		drain_pipeline();
		sink_idle = 0;
	endtask

	// half-lsb products check rounding ties towards plus infinity
	task automatic test_rounding_ties();
		load_taps('{TAP_HALF, '0, '0, '0}, '{-TAP_HALF, '0, '0, '0});
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
		drain_pipeline();
	endtask

	// receiver holds off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		tap_arr_t lo;
		tap_arr_t hi;
		for (int k = 0; k < NUM_TAP_REGS; k++) begin
			lo[k] = rand_tap();
			hi[k] = rand_tap();
		end
		load_taps(lo, hi);
		src_idle = 0;
		sink_idle = 0;
		sink_hold = 300;
		for (int n = 0; n < 3; n++) begin
			send_signal(20);
		end
		drain_pipeline();
		sink_idle = 40;
		src_idle = 40;
		send_signal(30);
		drain_pipeline();
	endtask

	task automatic test_random_signals();
		int unsigned target;
		int unsigned sig;
		tap_arr_t lo;
		tap_arr_t hi;
		target = items_sent + RANDOM_ITEMS;
		sig = 0;
		while (items_sent < target) begin
			if (sig % 6 == 0) begin
				drain_pipeline();
				for (int k = 0; k < NUM_TAP_REGS; k++) begin
					lo[k] = rand_tap();
					hi[k] = rand_tap();
				end
				load_taps(lo, hi);
			end
			src_idle = pick_idle();
			sink_idle = pick_idle();
			send_signal(pick_length());
			sig++;
		end
		drain_pipeline();
		// leave the block on its reset taps
		load_taps(LOW_TAP_RST, HIGH_TAP_RST);
		src_idle = 0;
		sink_idle = 20;
		send_signal(9);
		drain_pipeline();
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_taps();
		test_flush_extremes();
		test_rounding_ties();
		test_backpressure();
		test_random_signals();
		if (expected_pairs.size() != 0) begin
			report_mismatch($sformatf("%0d pairs never arrived", expected_pairs.size()));
		end
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
design/dwtas_pkg.sv
design/dwtas_cell.sv
design/dwt_analysis_stage_unit.sv
verif/dwt_analysis_stage_unit_test.sv
